// ===== hdl/sqd_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types of the shortest-queue dispatcher
package sqd_pkg;

	localparam int MAX_QUEUES = 4;
	localparam int MAX_DEPTH = 8;

	localparam int QW = 2;
	localparam int PTR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int FILL_W = 4;
	localparam int CNT_W = 3;
	localparam int TAG_W = 16;
	localparam int TIME_W = 16;
	localparam int ENTRY_W = TAG_W + TIME_W;
	localparam int ADDR_W = QW + PTR_W;
	localparam int STORE_DEPTH = MAX_QUEUES * MAX_DEPTH;
	localparam int KEY_W = FILL_W + CNT_W;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

	localparam logic [CNT_W-1:0] ACTIVE_RESET = 3'd4;
	localparam logic [FILL_W-1:0] LIMIT_RESET = 4'd3;

	localparam logic MODE_ARRIVE = 1'b0;
	localparam logic MODE_SERVE = 1'b1;

	localparam logic [1:0] STAT_ENQ = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_SERVED = 2'd2;
	localparam logic [1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} sqd_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic pop_load;
	} sqd_cmd_t;

	typedef struct packed {
		logic need_read;
	} sqd_stat_t;

endpackage

// ===== hdl/shortest_queue_dispatcher.sv =====
`timescale 1ns / 1ps
// top level of the join-shortest-queue dispatcher
//
//  channel   handshake             payload
//  command   start / busy          mode, client_tag, service_time, queue_select, scan_start
//  result    done (one cycle)      status, queue_used, served_tag, served_time, fill_after
//  config    cfg_we                cfg_index, cfg_wdata
//
// an arrive beat is accepted, then scanned and pushed; the result shows the cycle after the push
// a serve beat of a non-empty queue adds a read state for the registered entry ram read
// busy is low while a result is shown, so the next beat may be taken in that cycle
// reset clears pointers and fill counts at once; the entry ram needs no clearing
// done cannot be held off: every result is shown for exactly one cycle
module shortest_queue_dispatcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           mode,
	input  logic [sqd_pkg::TAG_W-1:0]      client_tag,
	input  logic [sqd_pkg::TIME_W-1:0]     service_time,
	input  logic [sqd_pkg::QW-1:0]         queue_select,
	input  logic [sqd_pkg::QW-1:0]         scan_start,
	output logic                           done,
	output logic [1:0]                     status,
	output logic [sqd_pkg::QW-1:0]         queue_used,
	output logic [sqd_pkg::TAG_W-1:0]      served_tag,
	output logic [sqd_pkg::TIME_W-1:0]     served_time,
	output logic [sqd_pkg::FILL_W-1:0]     fill_after,
	input  logic                           cfg_we,
	input  logic [sqd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sqd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	sqd_pkg::sqd_cmd_t  cmd;
	sqd_pkg::sqd_stat_t stat;

	sqd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	sqd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.client_tag  (client_tag),
		.service_time(service_time),
		.queue_select(queue_select),
		.scan_start  (scan_start),
		.done        (done),
		.status      (status),
		.queue_used  (queue_used),
		.served_tag  (served_tag),
		.served_time (served_time),
		.fill_after  (fill_after)
	);

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without work in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted beat did not start work");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> fill_after <= sqd_pkg::FILL_W'(sqd_pkg::MAX_DEPTH))
		else $error("fill beyond queue depth");

	a_no_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != sqd_pkg::STAT_SERVED) |-> served_tag == '0 && served_time == '0)
		else $error("served payload on a non-serve result");

endmodule

// ===== hdl/sqd_ram.sv =====
`timescale 1ns / 1ps
// generic single-write, registered-read ram
module sqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/sqd_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine of the shortest-queue dispatcher
module sqd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sqd_pkg::sqd_stat_t stat,
	output sqd_pkg::sqd_cmd_t  cmd,
	output logic              busy
);

	sqd_pkg::sqd_state_t state_q;
	sqd_pkg::sqd_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sqd_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = sqd_pkg::ST_EXEC;
				end
			end
			sqd_pkg::ST_EXEC: begin
				state_nxt = stat.need_read ? sqd_pkg::ST_READ : sqd_pkg::ST_IDLE;
			end
			sqd_pkg::ST_READ: begin
				state_nxt = sqd_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = sqd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			sqd_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
			end
			sqd_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			sqd_pkg::ST_READ: begin
				cmd.pop_load = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/sqd_datapath.sv =====
`timescale 1ns / 1ps
// queue pointers, fill counters, shortest-queue scan and result registers
module sqd_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sqd_pkg::sqd_cmd_t                cmd,
	output sqd_pkg::sqd_stat_t               stat,
	input  logic                             cfg_we,
	input  logic [sqd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sqd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             mode,
	input  logic [sqd_pkg::TAG_W-1:0]        client_tag,
	input  logic [sqd_pkg::TIME_W-1:0]       service_time,
	input  logic [sqd_pkg::QW-1:0]           queue_select,
	input  logic [sqd_pkg::QW-1:0]           scan_start,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [sqd_pkg::QW-1:0]           queue_used,
	output logic [sqd_pkg::TAG_W-1:0]        served_tag,
	output logic [sqd_pkg::TIME_W-1:0]       served_time,
	output logic [sqd_pkg::FILL_W-1:0]       fill_after
);

	localparam int NQ = sqd_pkg::MAX_QUEUES;

	logic [sqd_pkg::CNT_W-1:0]  active_q;
	logic [sqd_pkg::FILL_W-1:0] limit_q;

	logic                        mode_q;
	logic [sqd_pkg::TAG_W-1:0]   tag_q;
	logic [sqd_pkg::TIME_W-1:0]  time_q;
	logic [sqd_pkg::QW-1:0]      qsel_q;
	logic [sqd_pkg::QW-1:0]      sstart_q;

	logic [sqd_pkg::PTR_W-1:0]  head_q [NQ];
	logic [sqd_pkg::PTR_W-1:0]  tail_q [NQ];
	logic [sqd_pkg::FILL_W-1:0] fill_q [NQ];

	logic                        done_q;
	logic [1:0]                  status_q;
	logic [sqd_pkg::QW-1:0]      queue_used_q;
	logic [sqd_pkg::TAG_W-1:0]   served_tag_q;
	logic [sqd_pkg::TIME_W-1:0]  served_time_q;
	logic [sqd_pkg::FILL_W-1:0]  fill_after_q;

	logic [sqd_pkg::CNT_W-1:0]   n_eff;
	logic [sqd_pkg::FILL_W-1:0]  lim_eff;
	logic [sqd_pkg::QW-1:0]      start_eff;
	logic [sqd_pkg::QW-1:0]      best_idx;
	logic [sqd_pkg::KEY_W-1:0]   best_key;
	logic [sqd_pkg::FILL_W-1:0]  best_fill;
	logic                        arr_full;
	logic [sqd_pkg::PTR_W-1:0]   tail_cur;
	logic [sqd_pkg::FILL_W-1:0]  srv_fill;
	logic                        srv_empty;
	logic [sqd_pkg::PTR_W-1:0]   head_cur;
	logic                        ram_we;
	logic [sqd_pkg::ADDR_W-1:0]  ram_waddr;
	logic [sqd_pkg::ADDR_W-1:0]  ram_raddr;
	logic [sqd_pkg::ENTRY_W-1:0] ram_rdata;

	function automatic logic [sqd_pkg::PTR_W-1:0] advance(
		input logic [sqd_pkg::PTR_W-1:0]  p,
		input logic [sqd_pkg::FILL_W-1:0] lim
	);
		logic [sqd_pkg::FILL_W-1:0] nx;
		nx = sqd_pkg::FILL_W'(p) + sqd_pkg::FILL_W'(1);
		return (nx >= lim) ? '0 : nx[sqd_pkg::PTR_W-1:0];
	endfunction

	// effective register values
	always_comb begin
		if (active_q == '0) begin
			n_eff = sqd_pkg::CNT_W'(1);
		end else if (active_q > sqd_pkg::CNT_W'(NQ)) begin
			n_eff = sqd_pkg::CNT_W'(NQ);
		end else begin
			n_eff = active_q;
		end
		if (limit_q == '0) begin
			lim_eff = sqd_pkg::FILL_W'(1);
		end else if (limit_q > sqd_pkg::FILL_W'(sqd_pkg::MAX_DEPTH)) begin
			lim_eff = sqd_pkg::FILL_W'(sqd_pkg::MAX_DEPTH);
		end else begin
			lim_eff = limit_q;
		end
	end

	// scan start modulo the active count
	always_comb begin
		logic [sqd_pkg::CNT_W-1:0] s;
		s = sqd_pkg::CNT_W'(sstart_q);
		for (int k = 0; k < NQ; k++) begin
			if (s >= n_eff) begin
				s = s - n_eff;
			end
		end
		start_eff = s[sqd_pkg::QW-1:0];
	end

	// smallest fill, ties go to the queue visited first
	always_comb begin
		logic [sqd_pkg::CNT_W-1:0] pos;
		logic [sqd_pkg::KEY_W-1:0] key;
		best_key = '1;
		best_idx = start_eff;
		for (int j = 0; j < NQ; j++) begin
			if (sqd_pkg::QW'(j) >= start_eff) begin
				pos = sqd_pkg::CNT_W'(j) - sqd_pkg::CNT_W'(start_eff);
			end else begin
				pos = sqd_pkg::CNT_W'(j) + n_eff - sqd_pkg::CNT_W'(start_eff);
			end
			key = {fill_q[j], pos};
			if ((sqd_pkg::CNT_W'(j) < n_eff) && (key < best_key)) begin
				best_key = key;
				best_idx = sqd_pkg::QW'(j);
			end
		end
		best_fill = best_key[sqd_pkg::KEY_W-1 -: sqd_pkg::FILL_W];
	end

	assign arr_full  = (best_fill >= lim_eff);
	assign tail_cur  = tail_q[best_idx];
	assign srv_fill  = fill_q[qsel_q];
	assign srv_empty = (srv_fill == '0);
	assign head_cur  = head_q[qsel_q];

	assign ram_we    = cmd.exec && (mode_q == sqd_pkg::MODE_ARRIVE) && !arr_full;
	assign ram_waddr = {best_idx, tail_cur};
	assign ram_raddr = {qsel_q, head_cur};

	assign stat.need_read = (mode_q == sqd_pkg::MODE_SERVE) && !srv_empty;

	sqd_ram #(
		.WIDTH(sqd_pkg::ENTRY_W),
		.DEPTH(sqd_pkg::STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data({tag_q, time_q}),
		.rd_addr(ram_raddr),
		.rd_data(ram_rdata)
	);

	// config and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= sqd_pkg::ACTIVE_RESET;
			limit_q  <= sqd_pkg::LIMIT_RESET;
			done_q   <= 1'b0;
			for (int i = 0; i < NQ; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sqd_pkg::REG_ACTIVE: active_q <= cfg_wdata[sqd_pkg::CNT_W-1:0];
					sqd_pkg::REG_LIMIT:  limit_q  <= cfg_wdata[sqd_pkg::FILL_W-1:0];
					default: ;
				endcase
			end
			done_q <= (cmd.exec && !stat.need_read) || cmd.pop_load;
			if (cmd.exec) begin
				if (mode_q == sqd_pkg::MODE_ARRIVE) begin
					if (!arr_full) begin
						tail_q[best_idx] <= advance(tail_cur, lim_eff);
						fill_q[best_idx] <= best_fill + sqd_pkg::FILL_W'(1);
					end
				end else if (!srv_empty) begin
					head_q[qsel_q] <= advance(head_cur, lim_eff);
					fill_q[qsel_q] <= srv_fill - sqd_pkg::FILL_W'(1);
				end
			end
		end
	end

	// captured beat and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			tag_q    <= client_tag;
			time_q   <= service_time;
			qsel_q   <= queue_select;
			sstart_q <= scan_start;
		end
		if (cmd.exec) begin
			served_tag_q  <= '0;
			served_time_q <= '0;
			if (mode_q == sqd_pkg::MODE_ARRIVE) begin
				queue_used_q <= best_idx;
				if (arr_full) begin
					status_q     <= sqd_pkg::STAT_FULL;
					fill_after_q <= best_fill;
				end else begin
					status_q     <= sqd_pkg::STAT_ENQ;
					fill_after_q <= best_fill + sqd_pkg::FILL_W'(1);
				end
			end else begin
				queue_used_q <= qsel_q;
				if (srv_empty) begin
					status_q     <= sqd_pkg::STAT_EMPTY;
					fill_after_q <= '0;
				end else begin
					status_q     <= sqd_pkg::STAT_SERVED;
					fill_after_q <= srv_fill - sqd_pkg::FILL_W'(1);
				end
			end
		end
		if (cmd.pop_load) begin
			served_tag_q  <= ram_rdata[sqd_pkg::ENTRY_W-1 -: sqd_pkg::TAG_W];
			served_time_q <= ram_rdata[sqd_pkg::TIME_W-1:0];
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign queue_used  = queue_used_q;
	assign served_tag  = served_tag_q;
	assign served_time = served_time_q;
	assign fill_after  = fill_after_q;

endmodule

// ===== bench/sqd_checker.sv =====
`timescale 1ns / 1ps
// checker that predicts every result beat of the shortest-queue dispatcher and compares it
module sqd_checker
	import sqd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic                  mode,
	input  logic [TAG_W-1:0]      client_tag,
	input  logic [TIME_W-1:0]     service_time,
	input  logic [QW-1:0]         queue_select,
	input  logic [QW-1:0]         scan_start,
	input  logic                  done,
	input  logic [1:0]            status,
	input  logic [QW-1:0]         queue_used,
	input  logic [TAG_W-1:0]      served_tag,
	input  logic [TIME_W-1:0]     served_time,
	input  logic [FILL_W-1:0]     fill_after,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic [1:0]        status;
		logic [QW-1:0]     queue;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] dur;
		logic [FILL_W-1:0] fill;
	} outcome_t;

	outcome_t dispatch_outcomes[$];
	logic [ENTRY_W-1:0] slots [STORE_DEPTH];
	logic [PTR_W-1:0] q_head [MAX_QUEUES];
	logic [PTR_W-1:0] q_tail [MAX_QUEUES];
	logic [FILL_W-1:0] q_fill [MAX_QUEUES];
	logic [CNT_W-1:0] active_cfg;
	logic [FILL_W-1:0] limit_cfg;
	outcome_t seen;
	outcome_t want;

	task automatic report(input string what);
		$display("sqd_checker: %0t %s", $time, what);
		mismatches++;
	endtask

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p, input int lim);
		int n;
		n = int'(p) + 1;
		return (n >= lim) ? '0 : PTR_W'(n);
	endfunction

	function automatic outcome_t dispatch_beat(input logic m, input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] dur, input logic [QW-1:0] sel, input logic [QW-1:0] scan);
		int n;
		int lim;
		int first;
		int best;
		int q;
		outcome_t res;
		n = (active_cfg == 0) ? 1 : (int'(active_cfg) > MAX_QUEUES) ? MAX_QUEUES
			: int'(active_cfg);
		lim = (limit_cfg == 0) ? 1 : (int'(limit_cfg) > MAX_DEPTH) ? MAX_DEPTH
			: int'(limit_cfg);
		res = '0;
		if (m == MODE_ARRIVE) begin
			first = int'(scan) % n;
			best = first;
			for (int i = 1; i < n; i++) begin
				q = (first + i) % n;
				if (q_fill[q] < q_fill[best])
					best = q;
			end
			res.queue = QW'(best);
			if (int'(q_fill[best]) >= lim) begin
				res.status = STAT_FULL;
			end else begin
				slots[best * MAX_DEPTH + int'(q_tail[best])] = {tag, dur};
				q_tail[best] = bump(q_tail[best], lim);
				q_fill[best] = q_fill[best] + 1'b1;
				res.status = STAT_ENQ;
			end
			res.fill = q_fill[best];
		end else begin
			q = int'(sel);
			res.queue = sel;
			if (q_fill[q] == 0) begin
				res.status = STAT_EMPTY;
			end else begin
				{res.tag, res.dur} = slots[q * MAX_DEPTH + int'(q_head[q])];
				q_head[q] = bump(q_head[q], lim);
				q_fill[q] = q_fill[q] - 1'b1;
				res.status = STAT_SERVED;
				res.fill = q_fill[q];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_QUEUES; i++) begin
				q_head[i] = '0;
				q_tail[i] = '0;
				q_fill[i] = '0;
			end
			active_cfg = ACTIVE_RESET;
			limit_cfg = LIMIT_RESET;
			dispatch_outcomes.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ACTIVE)
					active_cfg = cfg_wdata[CNT_W-1:0];
				else if (cfg_index == REG_LIMIT)
					limit_cfg = cfg_wdata[FILL_W-1:0];
			end
			// result beat is checked before the beat taken at this edge is queued
			if (done) begin
				seen = '{status, queue_used, served_tag, served_time, fill_after};
				if (dispatch_outcomes.size() == 0) begin
					report($sformatf("result beat with nothing pending, status %0d", status));
				end else begin
					want = dispatch_outcomes.pop_front();
					if (seen.status != want.status)
						report($sformatf("status %0d, predicted %0d", seen.status,
							want.status));
					if (seen.queue != want.queue)
						report($sformatf("queue_used %0d, predicted %0d", seen.queue,
							want.queue));
					if (seen.tag != want.tag)
						report($sformatf("served_tag %h, predicted %h", seen.tag, want.tag));
					if (seen.dur != want.dur)
						report($sformatf("served_time %h, predicted %h", seen.dur, want.dur));
					if (seen.fill != want.fill)
						report($sformatf("fill_after %0d, predicted %0d", seen.fill,
							want.fill));
				end
			end
			if (start && !busy)
				dispatch_outcomes.push_back(dispatch_beat(mode, client_tag, service_time,
					queue_select, scan_start));
			outstanding <= dispatch_outcomes.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// testbench top: drives command and config beats into the dispatcher and gives the verdict
module tb;
	import sqd_pkg::*;

	localparam int STALL_LIMIT = 300;
	localparam int PHASES = 10;
	localparam int PHASE_BEATS = 160;
	localparam int SETTLE_CYCLES = 6;
	// active count and limit per phase, including out-of-range and masked values
	localparam logic [4*PHASES-1:0] ACTIVE_PLAN =
		{4'd4, 4'd10, 4'd6, 4'd13, 4'd3, 4'd2, 4'd7, 4'd0, 4'd4, 4'd1};
	localparam logic [4*PHASES-1:0] LIMIT_PLAN =
		{4'd3, 4'd4, 4'd2, 4'd9, 4'd8, 4'd5, 4'd15, 4'd0, 4'd8, 4'd1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = MODE_ARRIVE;
	logic [TAG_W-1:0] client_tag = '0;
	logic [TIME_W-1:0] service_time = '0;
	logic [QW-1:0] queue_select = '0;
	logic [QW-1:0] scan_start = '0;
	logic done;
	logic [1:0] status;
	logic [QW-1:0] queue_used;
	logic [TAG_W-1:0] served_tag;
	logic [TIME_W-1:0] served_time;
	logic [FILL_W-1:0] fill_after;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ACTIVE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	logic eager = 1'b0;

	shortest_queue_dispatcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.client_tag   (client_tag),
		.service_time (service_time),
		.queue_select (queue_select),
		.scan_start   (scan_start),
		.done         (done),
		.status       (status),
		.queue_used   (queue_used),
		.served_tag   (served_tag),
		.served_time  (served_time),
		.fill_after   (fill_after),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	sqd_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.client_tag   (client_tag),
		.service_time (service_time),
		.queue_select (queue_select),
		.scan_start   (scan_start),
		.done         (done),
		.status       (status),
		.queue_used   (queue_used),
		.served_tag   (served_tag),
		.served_time  (served_time),
		.fill_after   (fill_after),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send(input logic m, input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] dur, input logic [QW-1:0] sel, input logic [QW-1:0] scan);
		mode <= m;
		client_tag <= tag;
		service_time <= dur;
		queue_select <= sel;
		scan_start <= scan;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off;
		int gap;
		gap = eager ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic arrive(input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] dur,
			input logic [QW-1:0] scan);
		send(MODE_ARRIVE, tag, dur, QW'($urandom_range(0, 3)), scan);
		hold_off();
	endtask

	task automatic serve(input logic [QW-1:0] sel);
		send(MODE_SERVE, TAG_W'($urandom), TIME_W'($urandom), sel, QW'($urandom_range(0, 3)));
		hold_off();
	endtask

	task automatic settle;
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// every queue, inactive ones too, is emptied before the registers change
	task automatic drain;
		for (int q = 0; q < MAX_QUEUES; q++)
			repeat (MAX_DEPTH) serve(QW'(q));
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] act, input logic [CFG_DATA_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE;
		cfg_wdata <= act;
		@(posedge clk);
		cfg_index <= REG_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int arrive_pct;
		arrive_pct = 50;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		serve(2'd0);
		arrive(16'h0000, 16'h0000, 2'd0);
		arrive(16'hffff, 16'hffff, 2'd3);
		arrive(16'h5555, 16'haaaa, 2'd1);
		arrive(16'haaaa, 16'h5555, 2'd2);
		for (int i = 0; i < 8; i++)
			arrive(TAG_W'($urandom), TIME_W'($urandom), QW'(i));
		// all queues at the limit now, so this one is turned away
		arrive(16'h1234, 16'h8001, 2'd1);
		serve(2'd3);
		arrive(16'h0f0f, 16'hf0f0, 2'd0);
		for (int q = 0; q < MAX_QUEUES; q++)
			serve(QW'(q));

		for (int p = 0; p < PHASES; p++) begin
			settle();
			drain();
			settle();
			configure(ACTIVE_PLAN[p*4 +: 4], LIMIT_PLAN[p*4 +: 4]);
			for (int k = 0; k < PHASE_BEATS; k++) begin
				if (k % 32 == 0) begin
					eager = ($urandom_range(0, 3) == 0);
					arrive_pct = $urandom_range(25, 75);
				end
				send(($urandom_range(0, 99) < arrive_pct) ? MODE_ARRIVE : MODE_SERVE,
					TAG_W'($urandom), TIME_W'($urandom), QW'($urandom_range(0, 3)),
					QW'($urandom_range(0, 3)));
				hold_off();
			end
		end
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/sqd_pkg.sv
hdl/sqd_ram.sv
hdl/sqd_ctrl.sv
hdl/sqd_datapath.sv
hdl/shortest_queue_dispatcher.sv
bench/sqd_checker.sv
bench/tb.sv
